>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the framed payload receiver.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mfpr_pkg.sv
// Package for the framed payload receiver: widths, codes, register defaults
// and the start marker table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfpr_pkg;

    localparam int LENGTH_WIDTH_DEF = 25;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_LEN_W   = 25;
    localparam int EVENT_W     = 3;
    localparam int INDEX_W     = 24;
    localparam int COUNT_W     = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH    = 2'd2;

    localparam logic [31:0]          TIMEOUT_RESET    = 32'(5 * 1000 * 1000);
    localparam logic [CFG_LEN_W-1:0] MAX_LENGTH_RESET = 25'(16 * 1024 * 1024);
    localparam logic [CFG_LEN_W-1:0] MIN_LENGTH_RESET = 25'd52;

    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ACK      = 3'd1;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LAST_ACK = 3'd3;
    localparam logic [EVENT_W-1:0] EV_REJECT   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 3'd5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] START_MARKER [8] = '{
        8'h4E, 8'h50, 8'h4C, 8'h4C, 8'h42, 8'h49, 8'h4E, 8'h7F
    };

endpackage

`default_nettype wire

>>> hw/rtl/magic_framed_payload_receiver_unit.sv
// Framed payload receiver top level: input register, frame state machine
// and result register. Depends on mfpr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// One request (a received byte or one time tick) is taken every cycle unless
// a full input register and a result waiting on m_ready hold s_ready low, and
// gives exactly one result through the input and result registers; the whole
// frame step (marker match, length gather and bounds check, payload count,
// silence counter with its 32-bit compare) runs combinationally between the
// input register and the result register. The input register lets one request
// enter while a result waits on m_ready. Configuration writes are taken in
// every cycle and belong only in idle periods; an index past the register list is ignored.
module magic_framed_payload_receiver_unit #(
    parameter int LENGTH_WIDTH = mfpr_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_op,
    input  wire logic [7:0]                       s_rx_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mfpr_pkg::EVENT_W-1:0]          m_event_res,
    output logic [7:0]                            m_payload_byte,
    output logic [mfpr_pkg::INDEX_W-1:0]          m_byte_index,
    output logic [31:0]                           m_frame_length,
    output logic [mfpr_pkg::COUNT_W-1:0]          m_received_count,
    output logic                                  m_muted,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mfpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mfpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfpr_pkg::*;

`include "assert_macros.svh"

    localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LENGTH_WIDTH);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    logic [31:0]          timeout_reg;
    logic [CFG_LEN_W-1:0] max_length_reg;
    logic [CFG_LEN_W-1:0] min_length_reg;

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    logic [1:0]              phase_reg, phase_next;
    logic [2:0]              marker_reg, marker_next;
    logic [1:0]              len_seen_reg, len_seen_next;
    logic [31:0]             len_shift_reg, len_shift_next;
    logic [LENGTH_WIDTH-1:0] expected_reg, expected_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic [31:0]             silence_reg, silence_next;
    logic                    mute_reg, mute_next;

    logic                 out_valid_reg;
    logic [EVENT_W-1:0]   ev_reg, ev_next;
    logic [7:0]           pbyte_reg, pbyte_next;
    logic [INDEX_W-1:0]   pidx_reg, pidx_next;
    logic [31:0]          flen_reg, flen_next;
    logic [COUNT_W-1:0]   rcount_reg, rcount_next;
    logic                 muted_reg;

    logic        advance;
    logic        clear;
    logic [31:0] silence_inc;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign m_valid          = out_valid_reg;
    assign m_event_res      = ev_reg;
    assign m_payload_byte   = pbyte_reg;
    assign m_byte_index     = pidx_reg;
    assign m_frame_length   = flen_reg;
    assign m_received_count = rcount_reg;
    assign m_muted          = muted_reg;

    assign silence_inc = (silence_reg == 32'hFFFF_FFFF) ? silence_reg : silence_reg + 32'd1;

    always_comb begin
        phase_next     = phase_reg;
        marker_next    = marker_reg;
        len_seen_next  = len_seen_reg;
        len_shift_next = len_shift_reg;
        expected_next  = expected_reg;
        count_next     = count_reg;
        silence_next   = silence_reg;
        mute_next      = mute_reg;
        clear          = 1'b0;
        ev_next        = EV_NONE;
        pbyte_next     = 8'd0;
        pidx_next      = '0;
        flen_next      = 32'd0;
        rcount_next    = '0;

        if (in_op_reg == OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                silence_next = silence_inc;
                if (silence_inc >= timeout_reg) begin
                    ev_next     = EV_TIMEOUT;
                    flen_next   = 32'(expected_reg);
                    rcount_next = COUNT_W'(count_reg);
                    clear       = 1'b1;
                end
            end
        end else begin
            silence_next = 32'd0;
            unique case (phase_reg)
                PH_IDLE: begin
                    if (in_byte_reg != START_MARKER[marker_reg]) begin
                        marker_next = (in_byte_reg == START_MARKER[0]) ? 3'd1 : 3'd0;
                    end else if (marker_reg == 3'd7) begin
                        marker_next    = 3'd0;
                        mute_next      = 1'b1;
                        phase_next     = PH_LENGTH;
                        len_seen_next  = 2'd0;
                        len_shift_next = 32'd0;
                    end else begin
                        marker_next = marker_reg + 3'd1;
                    end
                end
                PH_LENGTH: begin
                    len_shift_next = {len_shift_reg[23:0], in_byte_reg};
                    if (len_seen_reg != 2'd3) begin
                        len_seen_next = len_seen_reg + 2'd1;
                    end else begin
                        flen_next = len_shift_next;
                        if ((len_shift_next > 32'(max_length_reg)) ||
                            (len_shift_next <= 32'(min_length_reg)) ||
                            (len_shift_next > LEN_MASK)) begin
                            ev_next = EV_REJECT;
                            clear   = 1'b1;
                        end else begin
                            ev_next       = EV_ACK;
                            phase_next    = PH_PAYLOAD;
                            len_seen_next = 2'd0;
                            expected_next = LENGTH_WIDTH'(len_shift_next);
                            count_next    = '0;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    pbyte_next = in_byte_reg;
                    pidx_next  = INDEX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                    if (count_next == expected_reg) begin
                        ev_next = EV_LAST_ACK;
                        clear   = 1'b1;
                    end else begin
                        ev_next = EV_PAYLOAD;
                    end
                end
                default: begin
                    clear = 1'b1;
                end
            endcase
        end

        if (clear) begin
            phase_next     = PH_IDLE;
            marker_next    = 3'd0;
            len_seen_next  = 2'd0;
            len_shift_next = 32'd0;
            expected_next  = '0;
            count_next     = '0;
            silence_next   = 32'd0;
            mute_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
            min_length_reg <= MIN_LENGTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMEOUT_TICKS: timeout_reg    <= cfg_data;
                REG_MAX_LENGTH:    max_length_reg <= CFG_LEN_W'(cfg_data);
                REG_MIN_LENGTH:    min_length_reg <= CFG_LEN_W'(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            marker_reg    <= 3'd0;
            len_seen_reg  <= 2'd0;
            len_shift_reg <= 32'd0;
            expected_reg  <= '0;
            count_reg     <= '0;
            silence_reg   <= 32'd0;
            mute_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg     <= phase_next;
                marker_reg    <= marker_next;
                len_seen_reg  <= len_seen_next;
                len_shift_reg <= len_shift_next;
                expected_reg  <= expected_next;
                count_reg     <= count_next;
                silence_reg   <= silence_next;
                mute_reg      <= mute_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ev_reg     <= ev_next;
            pbyte_reg  <= pbyte_next;
            pidx_reg   <= pidx_next;
            flen_reg   <= flen_next;
            rcount_reg <= rcount_next;
            muted_reg  <= mute_next;
        end
    end

    `ASSERT_SYNC(a_mute_tracks_phase, aclk, aresetn,
        (mute_reg == (phase_reg != PH_IDLE)),
        "mute flag disagrees with frame phase")
    `ASSERT_SYNC(a_count_below_length, aclk, aresetn,
        ((phase_reg == PH_PAYLOAD) |-> (count_reg < expected_reg)),
        "payload count reached expected length inside a frame")
    `ASSERT_SYNC(a_last_unmutes, aclk, aresetn,
        ((out_valid_reg && ((ev_reg == EV_LAST_ACK) || (ev_reg == EV_REJECT) ||
          (ev_reg == EV_TIMEOUT))) |-> !muted_reg),
        "frame end reported while still muted")
    `ASSERT_SYNC(a_input_held, aclk, aresetn,
        ((in_valid_reg && !advance) |=> in_valid_reg),
        "buffered request dropped without being processed")

endmodule

`default_nettype wire

>>> sim/magic_framed_payload_receiver_unit_test.sv
// Testbench for magic_framed_payload_receiver_unit: random and directed byte/tick
// requests, a request-level frame predictor and field-by-field result checks.
// Depends on mfpr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module magic_framed_payload_receiver_unit_test;

    import mfpr_pkg::*;

    localparam int CLOCK_HALF   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 8;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int SHORT_FRAME  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [31:0] LEN_LIMIT = (32'd1 << LENGTH_WIDTH_DEF) - 32'd1;

    typedef enum logic [1:0] {
        HUNT_MARKER,
        GATHER_LENGTH,
        FORWARD_PAYLOAD
    } rx_phase_e;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } rx_request_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [7:0]         payload_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [31:0]        frame_length;
        logic [COUNT_W-1:0] received_count;
        logic               muted;
    } frame_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_op      = OP_BYTE;
    logic [7:0]             s_rx_byte = 8'd0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [EVENT_W-1:0]     m_event_res;
    logic [7:0]             m_payload_byte;
    logic [INDEX_W-1:0]     m_byte_index;
    logic [31:0]            m_frame_length;
    logic [COUNT_W-1:0]     m_received_count;
    logic                   m_muted;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_TIMEOUT_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    magic_framed_payload_receiver_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_byte_index    (m_byte_index),
        .m_frame_length  (m_frame_length),
        .m_received_count(m_received_count),
        .m_muted         (m_muted),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // register shadow
    logic [31:0]          cfg_timeout = TIMEOUT_RESET;
    logic [CFG_LEN_W-1:0] cfg_max     = MAX_LENGTH_RESET;
    logic [CFG_LEN_W-1:0] cfg_min     = MIN_LENGTH_RESET;

    // frame state mirror
    rx_phase_e                   rx_phase   = HUNT_MARKER;
    logic [3:0]                  marker_pos = '0;
    logic [1:0]                  len_bytes  = '0;
    logic [31:0]                 len_shift  = '0;
    logic [LENGTH_WIDTH_DEF-1:0] exp_len    = '0;
    logic [LENGTH_WIDTH_DEF-1:0] pay_count  = '0;
    logic [31:0]                 silence    = '0;
    logic                        mute       = 1'b0;

    rx_request_t   pending_q[$];
    frame_result_t result_q[$];

    int  queued      = 0;
    int  taken_count = 0;
    int  fault_count = 0;
    int  cycle_count = 0;
    logic in_taken   = 1'b0;
    int  in_gap      = 0;
    int  in_steady   = 0;
    int  out_gap     = 0;
    int  out_steady  = 0;
    int  hold_left   = 0;
    logic hold_done  = 1'b0;

    function automatic void clear_frame();
        rx_phase   = HUNT_MARKER;
        marker_pos = '0;
        len_bytes  = '0;
        len_shift  = '0;
        exp_len    = '0;
        pay_count  = '0;
        silence    = '0;
        mute       = 1'b0;
    endfunction

    function automatic logic length_ok(logic [31:0] len);
        return len > 32'(cfg_min) && len <= 32'(cfg_max) && len <= LEN_LIMIT;
    endfunction

    function automatic frame_result_t predict_step(logic op, logic [7:0] b);
        frame_result_t r;
        r = '0;
        if (op == OP_TICK) begin
            if (rx_phase != HUNT_MARKER) begin
                if (silence != '1) silence++;
                if (silence >= cfg_timeout) begin
                    r.event_res      = EV_TIMEOUT;
                    r.frame_length   = 32'(exp_len);
                    r.received_count = COUNT_W'(pay_count);
                    clear_frame();
                end
            end
        end else begin
            silence = '0;
            case (rx_phase)
                HUNT_MARKER: begin
                    if (b != START_MARKER[marker_pos[2:0]]) begin
                        marker_pos = (b == START_MARKER[0]) ? 4'd1 : 4'd0;
                    end else if (marker_pos[2:0] == 3'd7) begin
                        marker_pos = '0;
                        mute       = 1'b1;
                        rx_phase   = GATHER_LENGTH;
                        len_bytes  = '0;
                        len_shift  = '0;
                    end else begin
                        marker_pos = {1'b0, marker_pos[2:0]} + 4'd1;
                    end
                end
                GATHER_LENGTH: begin
                    len_shift = {len_shift[23:0], b};
                    if (len_bytes != 2'd3) begin
                        len_bytes++;
                    end else begin
                        r.frame_length = len_shift;
                        if (!length_ok(len_shift)) begin
                            r.event_res = EV_REJECT;
                            clear_frame();
                        end else begin
                            r.event_res = EV_ACK;
                            rx_phase    = FORWARD_PAYLOAD;
                            len_bytes   = '0;
                            exp_len     = len_shift[LENGTH_WIDTH_DEF-1:0];
                            pay_count   = '0;
                        end
                    end
                end
                default: begin
                    r.payload_byte = b;
                    r.byte_index   = pay_count[INDEX_W-1:0];
                    pay_count++;
                    if (pay_count == exp_len) begin
                        r.event_res = EV_LAST_ACK;
                        clear_frame();
                    end else begin
                        r.event_res = EV_PAYLOAD;
                    end
                end
            endcase
        end
        r.muted = mute;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int next_gap(inout int steady);
        int r;
        if (steady != 0) begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) steady = $urandom_range(30, 120);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #CLOCK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin : track_and_check
        frame_result_t want;
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TIMEOUT_TICKS: cfg_timeout = cfg_data;
                    REG_MAX_LENGTH:    cfg_max     = cfg_data[CFG_LEN_W-1:0];
                    REG_MIN_LENGTH:    cfg_min     = cfg_data[CFG_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                result_q.push_back(predict_step(s_op, s_rx_byte));
                taken_count++;
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with none pending: event_res %0d", m_event_res);
                    fault_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(m_event_res));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(m_payload_byte));
                    check_field("byte_index", 32'(want.byte_index), 32'(m_byte_index));
                    check_field("frame_length", want.frame_length, m_frame_length);
                    check_field("received_count", 32'(want.received_count),
                                32'(m_received_count));
                    check_field("muted", 32'(want.muted), 32'(m_muted));
                end
            end
        end
    end

    always @(negedge aclk) begin : drive_requests
        rx_request_t nxt;
        logic        vld;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            vld = s_valid && !in_taken;
            if (!vld) begin
                if (in_gap != 0) begin
                    in_gap--;
                end else if (pending_q.size() != 0) begin
                    nxt = pending_q.pop_front();
                    s_op      <= nxt.op;
                    s_rx_byte <= nxt.rx_byte;
                    vld = 1'b1;
                    in_gap = (hold_left != 0) ? 0 : next_gap(in_steady);
                end
            end
            s_valid <= vld;
        end
    end

    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && taken_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (out_gap != 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            out_gap = next_gap(out_steady);
        end
    end

    task automatic put_byte(logic [7:0] b);
        pending_q.push_back('{op: OP_BYTE, rx_byte: b});
        queued++;
    endtask

    task automatic put_tick(int n);
        repeat (n) begin
            pending_q.push_back('{op: OP_TICK, rx_byte: 8'($urandom)});
            queued++;
        end
    endtask

    task automatic put_marker(int n);
        for (int i = 0; i < n; i++) put_byte(START_MARKER[i]);
    endtask

    // a few ticks that stay under the timeout
    task automatic short_pause();
        if (cfg_timeout >= 2)
            put_tick((cfg_timeout > 4) ? $urandom_range(1, 3) : $urandom_range(1, cfg_timeout - 1));
    endtask

    task automatic timeout_ticks();
        put_tick((cfg_timeout == 0) ? 1 : int'(cfg_timeout));
    endtask

    task automatic put_length(logic [31:0] len);
        for (int k = 3; k >= 0; k--) begin
            if ($urandom_range(0, 9) == 0) short_pause();
            put_byte(len[8*k +: 8]);
        end
    endtask

    task automatic gen_stream(int n);
        int          stop_at;
        int          sent;
        logic [31:0] len;
        stop_at = queued + n;
        while (queued < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 2) == 0) put_tick(1);
                        else put_byte(8'($urandom));
                    end
                end
                1: begin
                    put_marker($urandom_range(1, 7));
                    put_byte(8'($urandom));
                end
                default: begin
                    put_marker(8);
                    if (cfg_timeout <= SHORT_FRAME && $urandom_range(0, 9) == 0) begin
                        repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
                        timeout_ticks();
                        continue;
                    end
                    case ($urandom_range(0, 9))
                        0: len = 32'(cfg_min);
                        1: len = 32'(cfg_min) + 32'd1;
                        2: len = 32'(cfg_max);
                        3: len = 32'(cfg_max) + 32'd1;
                        4: len = $urandom;
                        5: len = 32'hFFFF_FFFF;
                        6: len = 32'd0;
                        default: len = 32'(cfg_min) + 32'd1 + $urandom_range(0, 20);
                    endcase
                    if (length_ok(len) && len > SHORT_FRAME && cfg_timeout > SHORT_FRAME)
                        len = 32'(cfg_max) + 32'd1;
                    put_length(len);
                    if (length_ok(len)) begin
                        if (len > SHORT_FRAME)
                            sent = $urandom_range(0, 5);
                        else if (cfg_timeout <= SHORT_FRAME && $urandom_range(0, 7) == 0)
                            sent = $urandom_range(0, len - 1);
                        else
                            sent = len;
                        for (int i = 0; i < sent; i++) begin
                            if ($urandom_range(0, 15) == 0) short_pause();
                            put_byte(8'($urandom));
                        end
                        if (sent < len) timeout_ticks();
                    end
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_valid || result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_limits(logic [31:0] timeout, logic [31:0] max_len, logic [31:0] min_len);
        wait_drained();
        put_reg(REG_TIMEOUT_TICKS, timeout);
        put_reg(REG_MAX_LENGTH, max_len);
        put_reg(REG_MIN_LENGTH, min_len);
        put_reg(REG_UNUSED, $urandom);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: idle ticks, marker restarts, length at the minimum
        put_tick(2);
        put_byte(START_MARKER[0]);
        put_byte(START_MARKER[1]);
        put_byte(START_MARKER[0]);
        put_byte(8'h58);
        put_marker(8);
        put_length(32'(MIN_LENGTH_RESET));
        gen_stream(150);

        // zero timeout, largest length accepted then dropped on one tick
        set_limits(32'd0, 32'd16777216, 32'd0);
        put_marker(8);
        put_length(32'd16777216);
        put_tick(1);
        put_marker(8);
        put_byte(8'd0);
        put_tick(1);
        gen_stream(80);

        set_limits(32'd1, 32'd0, 32'd0);
        gen_stream(60);

        set_limits(32'd4, 32'd24, 32'd3);
        gen_stream(350);

        set_limits(32'hFFFF_FFFF, 32'd40, 32'd0);
        gen_stream(300);

        set_limits(32'd12, 32'd16777216, 32'd16777215);
        gen_stream(100);

        set_limits(32'd7, 32'd16777216, 32'd16777216);
        gen_stream(40);

        set_limits(32'd2, 32'd30, 32'd1);
        gen_stream(170);

        wait_drained();
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mfpr_pkg.sv
hw/rtl/magic_framed_payload_receiver_unit.sv
sim/magic_framed_payload_receiver_unit_test.sv
